// File: hw/rtl/ffpc_pkg.sv
// Shared types and constants for the flat-field pixel correction block.
package ffpc_pkg;

  typedef enum logic [1:0] {
    REQ_CAL  = 2'd0,
    REQ_COR  = 2'd1,
    REQ_LOAD = 2'd2,
    REQ_NONE = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    REG_CLIP_MAX   = 3'd0,
    REG_FULL_SCALE = 3'd1,
    REG_LANE_STRD  = 3'd2,
    REG_RED_BASE   = 3'd3,
    REG_GREEN_BASE = 3'd4,
    REG_BLUE_BASE  = 3'd5,
    REG_PIX_IN_LN  = 3'd6
  } reg_e;

  localparam int unsigned FracBits  = 16;
  localparam int unsigned NumBits   = 31;  // full_scale << 16
  localparam int unsigned FullAddrW = 18;  // holds any raw table address
  localparam logic [31:0] UnityGain = 32'h0001_0000;

endpackage

// File: hw/rtl/flat_field_pixel_correction.sv
// Flat-field pixel correction: top level with pipelined divider and table RAM.
//
// Channel   Dir  Handshake             Payload
// request   in   start & !busy         req_type_i .. gain_value_i
// result    out  done_o (one cycle)    pixel_out_o, offset_out_o, gain_out_o, bad_address_o
// config    in   cfg_valid_i & cfg_ready_o  cfg_index_i, cfg_data_i
//
// One item per clock, every clock; busy never rises.
// From the accepting edge to done_o an item passes the input reg (loaded at that edge),
// address stage, one divider stage per quotient bit (31), table access, multiply and
// clip/output reg.
// All items pass every stage, and table writes and reads happen in one stage in
// item order, so a read always sees every earlier write.
// Reset sets the config registers to their defaults and clears the valid bits; the tables are not cleared.
module flat_field_pixel_correction #(
  parameter int unsigned LANES       = 3,
  parameter int unsigned LANE_DEPTH  = 4096,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic [2:0]  lane_index_i,
  input  logic [1:0]  color_sel_i,
  input  logic [11:0] pixel_index_i,
  input  logic [15:0] sample_value_i,
  input  logic [15:0] black_value_i,
  input  logic signed [31:0] gain_value_i,
  output logic        done_o,
  output logic [15:0] pixel_out_o,
  output logic [15:0] offset_out_o,
  output logic signed [31:0] gain_out_o,
  output logic        bad_address_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned TableSize = LANES * LANE_DEPTH;
  localparam int unsigned AddrW     = $clog2(TableSize);
  localparam int unsigned DivSteps  = ffpc_pkg::NumBits;
  localparam int unsigned Latency   = DivSteps + 4;
  localparam logic [15:0] SampleMask = 16'((32'd1 << SAMPLE_BITS) - 1);

  typedef struct packed {
    logic              vld;
    ffpc_pkg::req_e    req;
    logic              bad;
    logic [15:0]       smp;
    logic [15:0]       blk;
    logic [31:0]       gin;
    logic [AddrW-1:0]  addr;
    logic              dzero;
    logic              dneg;
    logic [15:0]       dmag;
    logic [15:0]       rem;
    logic [DivSteps-1:0] num;  // numerator bits, quotient shifts in at the bottom
  } dv_t;

  typedef struct packed {
    logic              vld;
    ffpc_pkg::req_e    req;
    logic              bad;
    logic [15:0]       smp;
    logic [15:0]       ofs;
    logic [31:0]       gain;
  } rd_t;

  // ---------------- configuration ----------------
  logic [15:0] clip_max_q;
  logic [14:0] full_scale_q;
  logic [12:0] lane_stride_q;
  logic [11:0] red_base_q, green_base_q, blue_base_q;
  logic [12:0] pix_in_lane_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_max_q    <= 16'd255;
      full_scale_q  <= 15'd255;
      lane_stride_q <= 13'd4096;
      red_base_q    <= '0;
      green_base_q  <= '0;
      blue_base_q   <= '0;
      pix_in_lane_q <= '0;
    end else if (cfg_valid_i) begin
      case (ffpc_pkg::reg_e'(cfg_index_i))
        ffpc_pkg::REG_CLIP_MAX:   clip_max_q    <= cfg_data_i;
        ffpc_pkg::REG_FULL_SCALE: full_scale_q  <= cfg_data_i[14:0];
        ffpc_pkg::REG_LANE_STRD:  lane_stride_q <= cfg_data_i[12:0];
        ffpc_pkg::REG_RED_BASE:   red_base_q    <= cfg_data_i[11:0];
        ffpc_pkg::REG_GREEN_BASE: green_base_q  <= cfg_data_i[11:0];
        ffpc_pkg::REG_BLUE_BASE:  blue_base_q   <= cfg_data_i[11:0];
        ffpc_pkg::REG_PIX_IN_LN:  pix_in_lane_q <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  // ---------------- input register ----------------
  logic        in_vld_q;
  logic [1:0]  in_req_q;
  logic [2:0]  in_lane_q;
  logic [1:0]  in_col_q;
  logic [11:0] in_pix_q;
  logic [15:0] in_smp_q, in_blk_q;
  logic [31:0] in_gin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start & ~busy;
    end
  end

  always_ff @(posedge clk_i) begin
    in_req_q  <= req_type_i;
    in_lane_q <= lane_index_i;
    in_col_q  <= color_sel_i;
    in_pix_q  <= pixel_index_i;
    in_smp_q  <= sample_value_i & SampleMask;
    in_blk_q  <= black_value_i & SampleMask;
    in_gin_q  <= gain_value_i;
  end

  // ---------------- address / range check ----------------
  logic [11:0] base;
  logic [ffpc_pkg::FullAddrW-1:0] addr_full;
  logic signed [16:0] diff;
  logic range_bad;
  dv_t pre_d, pre_q;

  always_comb begin
    case (in_col_q)
      2'd0:    base = red_base_q;
      2'd1:    base = green_base_q;
      default: base = blue_base_q;
    endcase
    addr_full = ffpc_pkg::FullAddrW'(lane_stride_q) * ffpc_pkg::FullAddrW'(in_lane_q)
              + ffpc_pkg::FullAddrW'(base) + ffpc_pkg::FullAddrW'(in_pix_q);
    range_bad = (32'(in_lane_q) >= LANES) || (in_col_q == 2'd3)
             || ({1'b0, in_pix_q} >= pix_in_lane_q)
             || (32'(addr_full) >= TableSize);
    diff = $signed({1'b0, in_smp_q}) - $signed({1'b0, in_blk_q});

    pre_d.vld   = in_vld_q;
    pre_d.req   = ffpc_pkg::req_e'(in_req_q);
    pre_d.bad   = range_bad && (ffpc_pkg::req_e'(in_req_q) != ffpc_pkg::REQ_NONE);
    pre_d.smp   = in_smp_q;
    pre_d.blk   = in_blk_q;
    pre_d.gin   = in_gin_q;
    pre_d.addr  = addr_full[AddrW-1:0];
    pre_d.dzero = (diff == 17'sd0);
    pre_d.dneg  = diff[16];
    pre_d.dmag  = diff[16] ? 16'(-diff) : diff[15:0];
    pre_d.rem   = '0;
    pre_d.num   = {full_scale_q, 16'd0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_q <= '0;
    end else begin
      pre_q <= pre_d;
    end
  end

  // ---------------- restoring divider, one quotient bit per stage ----------------
  dv_t dv_q [DivSteps];
  dv_t dv_d [DivSteps];

  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    dv_t         src;
    logic [16:0] trial;
    if (k == 0) begin : g_first
      assign src = pre_q;
    end else begin : g_next
      assign src = dv_q[k-1];
    end

    always_comb begin
      dv_d[k] = src;
      trial   = {src.rem, src.num[DivSteps-1]};
      if (trial >= {1'b0, src.dmag}) begin
        dv_d[k].rem = 16'(trial - {1'b0, src.dmag});
        dv_d[k].num = {src.num[DivSteps-2:0], 1'b1};
      end else begin
        dv_d[k].rem = trial[15:0];
        dv_d[k].num = {src.num[DivSteps-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k] <= '0;
      end else begin
        dv_q[k] <= dv_d[k];
      end
    end
  end

  // ---------------- table access ----------------
  dv_t         wr;
  logic [31:0] quot, cal_gain;
  logic        ram_we;
  logic [47:0] ram_wdata, ram_rdata;
  rd_t         rd_d, rd_q;

  assign wr = dv_q[DivSteps-1];

  always_comb begin
    quot     = {1'b0, wr.num};
    cal_gain = wr.dzero ? ffpc_pkg::UnityGain : (wr.dneg ? -quot : quot);
    ram_we   = wr.vld && !wr.bad
            && (wr.req == ffpc_pkg::REQ_CAL || wr.req == ffpc_pkg::REQ_LOAD);
    rd_d.vld = wr.vld;
    rd_d.req = wr.req;
    rd_d.bad = wr.bad;
    rd_d.smp = wr.smp;
    case (wr.req)
      ffpc_pkg::REQ_CAL: begin
        rd_d.ofs  = wr.blk;
        rd_d.gain = cal_gain;
      end
      ffpc_pkg::REQ_LOAD: begin
        rd_d.ofs  = wr.smp;
        rd_d.gain = wr.gin;
      end
      default: begin
        rd_d.ofs  = '0;
        rd_d.gain = '0;
      end
    endcase
    ram_wdata = {rd_d.ofs, rd_d.gain};
  end

  ffpc_ram #(
    .Width (48),
    .Depth (TableSize)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (wr.addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= '0;
    end else begin
      rd_q <= rd_d;
    end
  end

  // ---------------- multiply ----------------
  logic [15:0] use_ofs;
  logic [31:0] use_gain;
  logic signed [16:0] val;
  logic signed [48:0] prod_d, prod_q;
  logic        m_vld_q, m_cor_q, m_bad_q;
  logic [15:0] m_ofs_q;
  logic [31:0] m_gain_q;

  always_comb begin
    if (rd_q.req == ffpc_pkg::REQ_COR) begin
      use_ofs  = ram_rdata[47:32];
      use_gain = ram_rdata[31:0];
    end else begin
      use_ofs  = rd_q.ofs;
      use_gain = rd_q.gain;
    end
    val    = $signed({1'b0, rd_q.smp}) - $signed({1'b0, use_ofs});
    prod_d = 49'(val) * 49'($signed(use_gain));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else begin
      m_vld_q <= rd_q.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= prod_d;
    m_cor_q  <= (rd_q.req == ffpc_pkg::REQ_COR) && !rd_q.bad;
    m_bad_q  <= rd_q.bad;
    m_ofs_q  <= (rd_q.bad || rd_q.req == ffpc_pkg::REQ_NONE) ? 16'd0 : use_ofs;
    m_gain_q <= (rd_q.bad || rd_q.req == ffpc_pkg::REQ_NONE) ? 32'd0 : use_gain;
  end

  // ---------------- shift, wrap, clip ----------------
  logic [31:0] wrapped;
  logic [15:0] clipped;

  always_comb begin
    wrapped = prod_q[ffpc_pkg::FracBits +: 32];  // floor shift, keep 32 bits
    if (wrapped[31]) begin
      clipped = '0;
    end else if (wrapped > {16'd0, clip_max_q}) begin
      clipped = clip_max_q;
    end else begin
      clipped = wrapped[15:0];
    end
  end

  logic        done_q, bad_q;
  logic [15:0] pix_q, ofs_q;
  logic [31:0] gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= m_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q  <= m_cor_q ? clipped : 16'd0;
    ofs_q  <= m_ofs_q;
    gain_q <= m_gain_q;
    bad_q  <= m_bad_q;
  end

  assign done_o        = done_q;
  assign pixel_out_o   = pix_q;
  assign offset_out_o  = ofs_q;
  assign gain_out_o    = gain_q;
  assign bad_address_o = bad_q;

  // ---------------- assertions ----------------
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && bad_address_o |-> pixel_out_o == 16'd0 && offset_out_o == 16'd0
                                && gain_out_o == 32'sd0)
    else $error("bad address result carries data");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q |-> ##Latency done_o)
    else $error("accepted beat produced no result");

  a_we_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> wr.vld && !wr.bad)
    else $error("table write without a valid in-range beat");

endmodule

// File: hw/rtl/ffpc_ram.sv
// Generic single-port RAM with registered read data.
module ffpc_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 12288
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule
